FILE: design/htfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htfcc_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final XOR
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // conversion constants
  localparam logic [12:0] TempScale  = 13'd4375;
  localparam int          TempShift  = 14;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [9:0]  HumScale   = 10'd625;
  localparam int          HumShift   = 12;

  // default depth of the frame queue between front and back
  localparam int FrameQueueDepth = 2;

  // one checked frame, handed from front to back
  typedef struct packed {
    logic        crc_bad;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } frame_t;

  // one byte folded into a running CRC, unrolled over its eight bits
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/humidity_temp_frame_check_convert_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   data_byte[7:0]                             frame_start
// m_axis    out  temperature_centi[14:0], humidity_centi    status
//                [28:15], zero pad [31:29]
//
// One byte per cycle in. The front folds each data byte into the CRC and
// checks each CRC byte; on the sixth byte the frame enters the queue, and
// the back scales it with one multiply per word into the output register.
// Reset clears the byte position and the CRC to 0xFF. The input stalls only
// while the frame queue is full, which happens when the output is held.

module humidity_temp_frame_check_convert_unit import htfcc_pkg::*; #(
  parameter int QueueDepth = FrameQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // temperature_centi, humidity_centi, pad
  output logic             m_axis_tuser    // status
);

  frame_t      push_frame, head_frame;
  logic        push, pop, full, empty, beat;
  logic [14:0] temp_centi;
  logic [13:0] hum_centi;

  assign s_axis_tready = !full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  htfcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .data_byte_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .frame_o       (push_frame),
    .push_o        (push)
  );

  htfcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .full_o  (full),
    .pop_i   (pop),
    .frame_o (head_frame),
    .empty_o (empty)
  );

  htfcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (head_frame),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .status_o     (m_axis_tuser),
    .temp_centi_o (temp_centi),
    .hum_centi_o  (hum_centi)
  );

  assign m_axis_tdata = {3'b000, hum_centi, temp_centi};

endmodule

`default_nettype wire

FILE: design/htfcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module htfcc_front import htfcc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,        // byte accepted this cycle
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_start_i,
  output frame_t          frame_o,
  output logic            push_o
);

  localparam logic [2:0] PosTempHi = 3'd0;
  localparam logic [2:0] PosTempLo = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi  = 3'd3;
  localparam logic [2:0] PosHumLo  = 3'd4;
  localparam logic [2:0] PosHumCrc = 3'd5;

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic        bad1_q, bad1_d;
  logic [7:0]  crc_fold;

  // frame start or an unused position restarts the frame
  assign pos_eff = (frame_start_i || pos_q > PosHumCrc) ? PosTempHi : pos_q;

  always_comb begin
    crc_fold = crc8_byte(crc_q, data_byte_i);
    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    bad1_d      = bad1_q;
    push_o      = 1'b0;
    if (beat_i) begin
      unique case (pos_eff)
        PosTempHi: begin
          temp_word_d = {data_byte_i, 8'h00};
          crc_d       = crc8_byte(CrcInit, data_byte_i);
          pos_d       = PosTempLo;
        end
        PosTempLo: begin
          temp_word_d = {temp_word_q[15:8], data_byte_i};
          crc_d       = crc_fold;
          pos_d       = PosTempCrc;
        end
        PosTempCrc: begin
          bad1_d = (data_byte_i != crc_q);
          crc_d  = CrcInit;
          pos_d  = PosHumHi;
        end
        PosHumHi: begin
          hum_word_d = {data_byte_i, 8'h00};
          crc_d      = crc8_byte(CrcInit, data_byte_i);
          pos_d      = PosHumLo;
        end
        PosHumLo: begin
          hum_word_d = {hum_word_q[15:8], data_byte_i};
          crc_d      = crc_fold;
          pos_d      = PosHumCrc;
        end
        default: begin
          push_o = 1'b1;
          crc_d  = CrcInit;
          pos_d  = PosTempHi;
        end
      endcase
    end
  end

  // frame handed to the queue on the humidity CRC byte
  assign frame_o.crc_bad   = bad1_q || (data_byte_i != crc_q);
  assign frame_o.temp_word = temp_word_q;
  assign frame_o.hum_word  = hum_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempHi;
      crc_q       <= CrcInit;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      bad1_q      <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
      bad1_q      <= bad1_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/htfcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module htfcc_queue import htfcc_pkg::*; #(
  parameter int Depth = FrameQueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t frame_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output frame_t      frame_o,
  output logic        empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign frame_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/htfcc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module htfcc_back import htfcc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire frame_t frame_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic        status_o,
  output logic [14:0] temp_centi_o,
  output logic [13:0] hum_centi_o
);

  logic [28:0] temp_prod;
  logic [25:0] hum_prod;
  logic [15:0] temp_sum;
  logic        valid_q;
  logic        status_q;
  logic [14:0] temp_q, temp_d;
  logic [13:0] hum_q, hum_d;

  // take the next frame when the output register is free or draining
  assign pop_o = !empty_i && (!valid_q || ready_i);

  // scale both words and offset the temperature, zeroed on a CRC mismatch
  always_comb begin
    temp_prod = 29'(TempScale) * 29'(frame_i.temp_word);
    hum_prod  = 26'(HumScale) * 26'(frame_i.hum_word);
    temp_sum  = {1'b0, temp_prod[28:TempShift]} - TempOffset;
    temp_d    = frame_i.crc_bad ? '0 : temp_sum[14:0];
    hum_d     = frame_i.crc_bad ? '0 : hum_prod[25:HumShift];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= frame_i.crc_bad;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign temp_centi_o = temp_q;
  assign hum_centi_o  = hum_q;

endmodule

`default_nettype wire
